FILE: src/bbsm_pkg.sv
// Shared types and constants for the button box stick mapper.
`default_nettype none
package bbsm_pkg;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_TRUE_Z_PRESS   = 2'd0;
   localparam logic [1:0] REG_LEDGEDASH_SOCD = 2'd1;
   localparam logic [1:0] REG_LS_IS_DTAUNT   = 2'd2;

   localparam logic [7:0] STICK_CENTER  = 8'd128;
   localparam logic [7:0] STICK_FULL    = 8'd228;
   localparam logic [7:0] TRIGGER_FULL  = 8'd140;
   localparam logic [7:0] TRIGGER_LIGHT = 8'd49;

   typedef struct packed {
      logic true_z_press;
      logic ledgedash_socd;
      logic ls_is_dtaunt;
   } bbsm_cfg_type;

   typedef struct packed {
      logic [4:0] dir_buttons;
      logic [5:0] modifier_buttons;
      logic [3:0] cstick_buttons;
      logic [5:0] face_buttons;
   } bbsm_req_type;

   // Cleaned directions plus the raw left-and-right condition.
   typedef struct packed {
      logic left;
      logic right;
      logic up;
      logic down;
      logic lr_both;
   } bbsm_dir_type;

   typedef struct packed {
      logic [7:0] stick_x;
      logic [7:0] stick_y;
      logic [7:0] cstick_x;
      logic [7:0] cstick_y;
      logic [7:0] trigger_left;
      logic [7:0] trigger_right;
      logic [3:0] dpad_bits;
      logic [7:0] report_buttons;
   } bbsm_rsp_type;

   // Reflects a stick byte about the center: (256 - b) mod 256.
   function automatic logic [7:0] mirror_byte(input logic [7:0] b);
      mirror_byte = 8'(-b);
   endfunction

endpackage
`default_nettype wire

FILE: src/bbsm_if.sv
// Valid/ready channel interfaces for button snapshots and controller reports.
`default_nettype none
interface bbsm_req_if;
   logic       valid;
   logic       ready;
   logic [4:0] dir_buttons;
   logic [5:0] modifier_buttons;
   logic [3:0] cstick_buttons;
   logic [5:0] face_buttons;

   modport source (output valid, dir_buttons, modifier_buttons, cstick_buttons,
                   face_buttons, input ready);
   modport sink (input valid, dir_buttons, modifier_buttons, cstick_buttons,
                 face_buttons, output ready);
endinterface

interface bbsm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] stick_x;
   logic [7:0] stick_y;
   logic [7:0] cstick_x;
   logic [7:0] cstick_y;
   logic [7:0] trigger_left;
   logic [7:0] trigger_right;
   logic [3:0] dpad_bits;
   logic [7:0] report_buttons;

   modport source (output valid, stick_x, stick_y, cstick_x, cstick_y, trigger_left,
                   trigger_right, dpad_bits, report_buttons, input ready);
   modport sink (input valid, stick_x, stick_y, cstick_x, cstick_y, trigger_left,
                 trigger_right, dpad_bits, report_buttons, output ready);
endinterface
`default_nettype wire

FILE: src/button_box_socd_stick_mapper_core.sv
// Top level of the button box SOCD stick mapper: input stage, mapping, report register.
`default_nettype none
// A transaction accepted into the input register moves on into the report register,
// where it is presented as a report until it is taken. Throughput, while reports are
// taken: one transaction per cycle; the input stage refills in the cycle it drains.
// The rate is set by the single input register and the single report register.
// Reset (synchronous, active high) empties both stages, clears the lockout state
// and loads the registers with true_z_press = 1, ledgedash_socd = 0, ls_is_dtaunt = 1.
module button_box_socd_stick_mapper_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   bbsm_req_if.sink                               req_bus,
   bbsm_rsp_if.source                             rsp_bus,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [bbsm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [bbsm_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [bbsm_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                   pready
);
   import bbsm_pkg::*;

   // Configuration registers. The APB port never stalls, so pready is tied high.
   // A write lands on the access cycle; only bit 0 of the write data is kept.
   bbsm_cfg_type cfg_ff, cfg_in;
   logic         cfg_write;
   logic [1:0]   reg_index;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;
   assign reg_index = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (reg_index)
            REG_TRUE_Z_PRESS:   cfg_in.true_z_press   = pwdata[0];
            REG_LEDGEDASH_SOCD: cfg_in.ledgedash_socd = pwdata[0];
            REG_LS_IS_DTAUNT:   cfg_in.ls_is_dtaunt   = pwdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_TRUE_Z_PRESS:   prdata = CSR_DATA_W'(cfg_ff.true_z_press);
         REG_LEDGEDASH_SOCD: prdata = CSR_DATA_W'(cfg_ff.ledgedash_socd);
         REG_LS_IS_DTAUNT:   prdata = CSR_DATA_W'(cfg_ff.ls_is_dtaunt);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{true_z_press: 1'b1, ledgedash_socd: 1'b0, ls_is_dtaunt: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Two-stage pipeline. The input stage holds one accepted transaction; it moves
   // into the report register whenever that register is empty or being drained,
   // so a waiting report blocks new snapshots only once the input stage is full too.
   logic         s1_valid_ff, s1_valid_in;
   bbsm_req_type s1_req_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   bbsm_rsp_type rsp_data_ff, rsp_data;
   logic         req_accept, rsp_load;
   bbsm_dir_type dirs;

   assign rsp_load       = s1_valid_ff & (~rsp_valid_ff | rsp_bus.ready);
   assign req_bus.ready  = ~s1_valid_ff | rsp_load;
   assign req_accept     = req_bus.valid & req_bus.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) s1_valid_in = 1'b1;
      else if (rsp_load) s1_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_bus.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= '{dir_buttons:      req_bus.dir_buttons,
                        modifier_buttons: req_bus.modifier_buttons,
                        cstick_buttons:   req_bus.cstick_buttons,
                        face_buttons:     req_bus.face_buttons};
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data;
      end
   end

   // The lockout state advances exactly once per transaction, when it leaves the
   // input stage, so every snapshot sees the state left by the one before it.
   bbsm_socd u_socd (
      .clock       (clock),
      .reset       (reset),
      .advance     (rsp_load),
      .dir_buttons (s1_req_ff.dir_buttons),
      .dirs        (dirs)
   );

   bbsm_map u_map (
      .cfg  (cfg_ff),
      .dirs (dirs),
      .req  (s1_req_ff),
      .rsp  (rsp_data)
   );

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.stick_x        = rsp_data_ff.stick_x;
   assign rsp_bus.stick_y        = rsp_data_ff.stick_y;
   assign rsp_bus.cstick_x       = rsp_data_ff.cstick_x;
   assign rsp_bus.cstick_y       = rsp_data_ff.cstick_y;
   assign rsp_bus.trigger_left   = rsp_data_ff.trigger_left;
   assign rsp_bus.trigger_right  = rsp_data_ff.trigger_right;
   assign rsp_bus.dpad_bits      = rsp_data_ff.dpad_bits;
   assign rsp_bus.report_buttons = rsp_data_ff.report_buttons;

   // A held input transaction stays until it moves to the report register.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_load) |=> s1_valid_ff)
      else $error("input stage lost a transaction");

   // Loading the report register always yields a valid report next cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("report missing after load");

   // The input stage only takes a new transaction when it is empty or draining.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_accept && s1_valid_ff) |-> rsp_load)
      else $error("input stage overwritten");

endmodule
`default_nettype wire

FILE: src/bbsm_socd.sv
// SOCD cleaning with the up/down lockout state.
`default_nettype none
module bbsm_socd (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic [4:0]            dir_buttons,
   output bbsm_pkg::bbsm_dir_type     dirs
);
   import bbsm_pkg::*;

   logic raw_l, raw_r, raw_u, raw_d;
   logic prev_up_ff, prev_down_ff, up_locked_ff, down_locked_ff;
   logic prev_up_in, prev_down_in, up_locked_in, down_locked_in;

   assign raw_l = dir_buttons[0];
   assign raw_r = dir_buttons[1];
   assign raw_u = dir_buttons[2] | dir_buttons[3];
   assign raw_d = dir_buttons[4];

   // A lock engages on the direction that was already held when its opposite
   // joins, and holds until that direction is released.
   always_comb begin
      up_locked_in   = raw_u & (up_locked_ff |
                                (prev_up_ff & raw_d & ~prev_down_ff));
      down_locked_in = raw_d & (down_locked_ff |
                                (prev_down_ff & raw_u & ~prev_up_ff));
      prev_up_in     = raw_u;
      prev_down_in   = raw_d;
   end

   always_comb begin
      dirs.lr_both = raw_l & raw_r;
      dirs.left    = raw_l & ~raw_r;
      dirs.right   = raw_r & ~raw_l;
      dirs.up      = raw_u & ~up_locked_in;
      dirs.down    = raw_d & ~down_locked_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_up_ff     <= 1'b0;
         prev_down_ff   <= 1'b0;
         up_locked_ff   <= 1'b0;
         down_locked_ff <= 1'b0;
      end else if (advance) begin
         prev_up_ff     <= prev_up_in;
         prev_down_ff   <= prev_down_in;
         up_locked_ff   <= up_locked_in;
         down_locked_ff <= down_locked_in;
      end
   end

   // The two locks exclude each other.
   a_locks_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(up_locked_ff && down_locked_ff))
      else $error("up and down locked together");

   // A lock only stands while its direction was held on the last transaction.
   a_up_lock_held: assert property (@(posedge clock) disable iff (reset)
      up_locked_ff |-> prev_up_ff)
      else $error("up lock without up held");

   a_down_lock_held: assert property (@(posedge clock) disable iff (reset)
      down_locked_ff |-> prev_down_ff)
      else $error("down lock without down held");

   // The cleaned up direction never survives its own lock.
   a_lock_masks: assert property (@(posedge clock) disable iff (reset)
      (advance && up_locked_ff && raw_u) |-> !dirs.up)
      else $error("locked up passed through");

endmodule
`default_nettype wire

FILE: src/bbsm_map.sv
// Maps cleaned directions and buttons to stick, trigger, d-pad and button fields.
`default_nettype none
module bbsm_map (
   input  bbsm_pkg::bbsm_cfg_type  cfg,
   input  bbsm_pkg::bbsm_dir_type  dirs,
   input  bbsm_pkg::bbsm_req_type  req,
   output bbsm_pkg::bbsm_rsp_type  rsp
);
   import bbsm_pkg::*;

   logic sl, sr, mx, my, ls, ms;
   logic cu, cd, cl, cr;
   logic vert, horiz, cvert, choriz;
   logic [7:0] x, y, cx, cy, tl;
   logic [3:0] dp;
   logic [7:0] btn;

   assign sl = req.modifier_buttons[0];
   assign sr = req.modifier_buttons[1];
   assign mx = req.modifier_buttons[2];
   assign my = req.modifier_buttons[3];
   assign ls = req.modifier_buttons[4];
   assign ms = req.modifier_buttons[5];
   assign cu = req.cstick_buttons[0];
   assign cd = req.cstick_buttons[1];
   assign cl = req.cstick_buttons[2];
   assign cr = req.cstick_buttons[3];

   assign vert   = dirs.up | dirs.down;
   assign horiz  = dirs.left | dirs.right;
   assign cvert  = cu ^ cd;
   assign choriz = cl ^ cr;

   // Main stick magnitudes for the first quadrant; signs applied afterward.
   always_comb begin
      x = STICK_CENTER;
      y = STICK_CENTER;
      if (vert && horiz) begin
         if (sl || sr) begin
            if (mx == my) begin x = 8'd198; y = 8'd198; end
            else if (mx)  begin x = 8'd200; y = 8'd159; end
            else          begin x = 8'd172; y = 8'd200; end
         end else if (mx != my) begin
            if (mx) begin
               if (cd)      begin x = 8'd210; y = 8'd164; end
               else if (cl) begin x = 8'd212; y = 8'd178; end
               else if (cu) begin x = 8'd205; y = 8'd183; end
               else if (cr) begin x = 8'd200; y = 8'd189; end
               else         begin x = 8'd198; y = 8'd162; end
            end else begin
               if (cd)      begin x = 8'd162; y = 8'd210; end
               else if (cl) begin x = 8'd168; y = 8'd212; end
               else if (cu) begin x = 8'd183; y = 8'd205; end
               else if (cr) begin x = 8'd190; y = 8'd200; end
               else         begin x = 8'd156; y = 8'd186; end
            end
         end else begin
            x = 8'd198;
            y = 8'd198;
         end
      end else if (horiz) begin
         if (mx == my) x = STICK_FULL;
         else if (mx)  x = 8'd198;
         else          x = 8'd163;
      end else if (vert) begin
         if (mx == my) y = STICK_FULL;
         else if (mx)  y = 8'd188;
         else          y = 8'd198;
      end
      if (cfg.ledgedash_socd && dirs.lr_both) x = STICK_FULL;
      if (horiz && !dirs.right) x = mirror_byte(x);
      if (vert && !dirs.up) y = mirror_byte(y);
   end

   // C-stick is centered when both modifiers are held.
   always_comb begin
      cx = STICK_CENTER;
      cy = STICK_CENTER;
      if (mx && my) begin
         cx = STICK_CENTER;
         cy = STICK_CENTER;
      end else if (cvert && choriz) begin
         cx = 8'd180;
         cy = 8'd213;
      end else if (choriz) begin
         if (mx) begin
            cx = 8'd212;
            cy = dirs.up ? 8'd159 : 8'd97;
         end else begin
            cx = STICK_FULL;
         end
      end else if (cvert) begin
         cy = STICK_FULL;
      end
      if (choriz && cl) cx = mirror_byte(cx);
      if (cvert && cd) cy = mirror_byte(cy);
   end

   always_comb begin
      dp = (mx && my) ? req.cstick_buttons : 4'b0000;
      if (ms) dp[0] = 1'b1;
      if (ls && cfg.ls_is_dtaunt) dp[1] = 1'b1;

      tl = sl ? TRIGGER_FULL : 8'd0;
      if (ls && !cfg.ls_is_dtaunt) tl = TRIGGER_LIGHT;

      btn = {req.face_buttons[5], sr, sl, 1'b0, req.face_buttons[3:0]};
      if (req.face_buttons[4]) begin
         if (cfg.true_z_press) begin
            btn[4] = 1'b1;
         end else begin
            tl     = TRIGGER_LIGHT;
            btn[0] = 1'b1;
         end
      end
   end

   always_comb begin
      rsp.stick_x        = x;
      rsp.stick_y        = y;
      rsp.cstick_x       = cx;
      rsp.cstick_y       = cy;
      rsp.trigger_left   = tl;
      rsp.trigger_right  = sr ? TRIGGER_FULL : 8'd0;
      rsp.dpad_bits      = dp;
      rsp.report_buttons = btn;
   end

endmodule
`default_nettype wire
